FILE: sv/gbr_pkg.sv
`timescale 1ns / 1ps
// gbr_pkg: widths, register indexes and output codes for the grid bisection
// reorder core. No dependencies.
package gbr_pkg;

    // field widths
    localparam int CFG_W     = 11;          // dimension register width
    localparam int IDX_W     = 30;          // vertex index width
    localparam int REG_IDX_W = 2;           // configuration register index width
    localparam int PROD_W    = 2 * CFG_W;   // product of two dimensions
    localparam int HALF_W    = CFG_W - 1;   // part extent along the cut axis

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GRID_DEPTH  = 2'd2;

    // part codes
    localparam logic [1:0] PART_LEFT  = 2'd0;
    localparam logic [1:0] PART_RIGHT = 2'd1;
    localparam logic [1:0] PART_SEP   = 2'd2;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

FILE: sv/grid_bisection_reorder_core.sv
`timescale 1ns / 1ps
// grid_bisection_reorder_core: one level of nested dissection on a regular
// grid, mapping a vertex index to its bisection order. Uses gbr_pkg.

// The core takes one vertex index per clock while the output is not stalled
// and returns one result per index, in order, through an input register, two
// 30-stage restoring dividers side by side (index by grid width, and index by
// the area of one z plane), stages p1 to p4 for the coordinate remap and the
// multiply-add of the new index, and the output register. A stall on the output
// holds the whole pipeline; nothing is lost or repeated. Through the cfg port,
// the user must write grid dimensions only while the core is empty, which the
// block leaves unchecked; zero reads as 1, above DIM_MAX saturates to DIM_MAX.
module grid_bisection_reorder_core import gbr_pkg::*; #(
    parameter int DIM_MAX = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // vertex index input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IDX_W-1:0]     s_vertex_index,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_new_index,
    output logic [1:0]           m_part,
    output logic [1:0]           m_split_axis,
    output logic [8:0]           m_left_extent,
    output logic [9:0]           m_right_extent,
    output logic [20:0]          m_separator_size,
    output logic                 m_index_error
);

    // dimension clamp: zero reads as one, large values saturate
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (32'(v) > DIM_MAX) begin
            r = CFG_W'(DIM_MAX);
        end
        return r;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] width_reg, height_reg, depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            depth_reg  <= CFG_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  width_reg  <= cfg_wdata;
                REG_GRID_HEIGHT: height_reg <= cfg_wdata;
                REG_GRID_DEPTH:  depth_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // grid figures, first step: clamped dims, cut axis, part extents
    logic [CFG_W-1:0]  n0_reg, n1_reg, n2_reg;
    logic [CFG_W-1:0]  n0_next, n1_next, n2_next, len_next, lenm1_next;
    logic [PROD_W-1:0] n01_reg, n01_next;
    logic [1:0]        axis_reg, axis_next;
    logic [HALF_W-1:0] left_reg, right_reg, left_next, right_next;

    always_comb begin
        n0_next  = clamp_dim(width_reg);
        n1_next  = clamp_dim(height_reg);
        n2_next  = clamp_dim(depth_reg);
        n01_next = PROD_W'(n0_next) * PROD_W'(n1_next);
        if (n0_next >= n1_next && n0_next >= n2_next) begin
            axis_next = AXIS_X;
            len_next  = n0_next;
        end else if (n1_next >= n2_next) begin
            axis_next = AXIS_Y;
            len_next  = n1_next;
        end else begin
            axis_next = AXIS_Z;
            len_next  = n2_next;
        end
        lenm1_next = len_next - CFG_W'(1);
        left_next  = lenm1_next[CFG_W-1:1];
        right_next = HALF_W'(lenm1_next - CFG_W'(left_next));
    end

    always_ff @(posedge aclk) begin
        n0_reg    <= n0_next;
        n1_reg    <= n1_next;
        n2_reg    <= n2_next;
        n01_reg   <= n01_next;
        axis_reg  <= axis_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    // grid figures, second step: separator size
    logic [PROD_W-1:0] sep_reg, sep_next;
    logic [CFG_W-1:0]  oth_a, oth_b;

    always_comb begin
        case (axis_reg)
            AXIS_X: begin
                oth_a = n1_reg;
                oth_b = n2_reg;
            end
            AXIS_Y: begin
                oth_a = n0_reg;
                oth_b = n2_reg;
            end
            default: begin
                oth_a = n0_reg;
                oth_b = n1_reg;
            end
        endcase
        sep_next = PROD_W'(oth_a) * PROD_W'(oth_b);
    end

    always_ff @(posedge aclk) begin
        sep_reg <= sep_next;
    end

    // grid figures, third step: start offsets of right part and separator
    logic [IDX_W-1:0] base_r_reg, base_s_reg, base_r_next, base_s_next;

    always_comb begin
        base_r_next = IDX_W'(32'(left_reg) * 32'(sep_reg));
        base_s_next = IDX_W'(33'(CFG_W'(left_reg) + CFG_W'(right_reg)) * 33'(sep_reg));
    end

    always_ff @(posedge aclk) begin
        base_r_reg <= base_r_next;
        base_s_reg <= base_s_next;
    end

    // pipeline advance: everything moves unless the output beat is stuck
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // divider pipeline: stage 0 is the input register, stage k+1 holds the
    // state after quotient bit k; a divides by width, b by the z plane area
    logic                 dv_reg [0:IDX_W];
    logic [IDX_W-1:0]     wa_reg [0:IDX_W];
    logic [IDX_W-1:0]     wb_reg [0:IDX_W];
    logic [CFG_W-1:0]     ra_reg [0:IDX_W];
    logic [PROD_W-1:0]    rb_reg [0:IDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wa_reg[0] <= s_vertex_index;
            wb_reg[0] <= s_vertex_index;
            ra_reg[0] <= '0;
            rb_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < IDX_W; k++) begin : g_div
        logic [CFG_W:0]    ta;
        logic [PROD_W:0]   tb;
        logic              ge_a, ge_b;
        logic [CFG_W-1:0]  ra_next;
        logic [PROD_W-1:0] rb_next;

        // one restoring step on each divider
        always_comb begin
            ta      = {ra_reg[k], wa_reg[k][IDX_W-1]};
            tb      = {rb_reg[k], wb_reg[k][IDX_W-1]};
            ge_a    = ta >= {1'b0, n0_reg};
            ge_b    = tb >= {1'b0, n01_reg};
            ra_next = ge_a ? CFG_W'(ta - {1'b0, n0_reg}) : ta[CFG_W-1:0];
            rb_next = ge_b ? PROD_W'(tb - {1'b0, n01_reg}) : tb[PROD_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                ra_reg[k+1] <= ra_next;
                rb_reg[k+1] <= rb_next;
                wa_reg[k+1] <= {wa_reg[k][IDX_W-2:0], ge_a};
                wb_reg[k+1] <= {wb_reg[k][IDX_W-2:0], ge_b};
            end
        end
    end

    // stage p1: bounds check on z, product for the y coordinate
    logic              p1_v_reg, p1_err_reg, p1_err_next;
    logic [CFG_W-1:0]  p1_c0_reg, p1_c2_reg;
    logic [PROD_W-1:0] p1_q0_reg, p1_prod_reg, p1_prod_next;

    always_comb begin
        p1_err_next  = wb_reg[IDX_W] >= IDX_W'(n2_reg);
        p1_prod_next = PROD_W'(wb_reg[IDX_W][CFG_W-1:0]) * PROD_W'(n1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
        end else if (adv) begin
            p1_v_reg <= dv_reg[IDX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_err_reg  <= p1_err_next;
            p1_prod_reg <= p1_prod_next;
            p1_c0_reg   <= ra_reg[IDX_W];
            p1_c2_reg   <= wb_reg[IDX_W][CFG_W-1:0];
            p1_q0_reg   <= wa_reg[IDX_W][PROD_W-1:0];
        end
    end

    // stage p2: classify along the cut axis, remap coordinates and extents
    logic             p2_v_reg, p2_err_reg;
    logic [1:0]       p2_part_reg, part_next;
    logic [CFG_W-1:0] p2_c0_reg, p2_c1_reg, p2_c2_reg, p2_e0_reg, p2_e1_reg;
    logic [CFG_W-1:0] c0, c1, c2, ca, ca_adj, ea, left_x, e0_next, e1_next;
    logic [IDX_W-1:0] p2_base_reg, base_next;

    always_comb begin
        c0     = p1_c0_reg;
        c1     = CFG_W'(p1_q0_reg - p1_prod_reg);
        c2     = p1_c2_reg;
        left_x = CFG_W'(left_reg);
        case (axis_reg)
            AXIS_X:  ca = c0;
            AXIS_Y:  ca = c1;
            default: ca = c2;
        endcase
        if (ca < left_x) begin
            part_next = PART_LEFT;
            ca_adj    = ca;
            ea        = left_x;
            base_next = '0;
        end else if (ca > left_x) begin
            part_next = PART_RIGHT;
            ca_adj    = ca - left_x - CFG_W'(1);
            ea        = CFG_W'(right_reg);
            base_next = base_r_reg;
        end else begin
            part_next = PART_SEP;
            ca_adj    = '0;
            ea        = CFG_W'(1);
            base_next = base_s_reg;
        end
        if (p1_err_reg) begin
            part_next = PART_LEFT;
        end
        e0_next = n0_reg;
        e1_next = n1_reg;
        case (axis_reg)
            AXIS_X: begin
                c0      = ca_adj;
                e0_next = ea;
            end
            AXIS_Y: begin
                c1      = ca_adj;
                e1_next = ea;
            end
            default: begin
                c2      = ca_adj;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_v_reg <= 1'b0;
        end else if (adv) begin
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_err_reg  <= p1_err_reg;
            p2_part_reg <= part_next;
            p2_c0_reg   <= c0;
            p2_c1_reg   <= c1;
            p2_c2_reg   <= c2;
            p2_e0_reg   <= e0_next;
            p2_e1_reg   <= e1_next;
            p2_base_reg <= base_next;
        end
    end

    // stage p3: row index inside the part, c1 + e1 * c2
    logic              p3_v_reg, p3_err_reg;
    logic [1:0]        p3_part_reg;
    logic [CFG_W-1:0]  p3_c0_reg, p3_e0_reg;
    logic [PROD_W-1:0] p3_h_reg, h_next;
    logic [IDX_W-1:0]  p3_base_reg;

    assign h_next = PROD_W'(p2_c1_reg) + PROD_W'(p2_e1_reg) * PROD_W'(p2_c2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_v_reg <= 1'b0;
        end else if (adv) begin
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_err_reg  <= p2_err_reg;
            p3_part_reg <= p2_part_reg;
            p3_c0_reg   <= p2_c0_reg;
            p3_e0_reg   <= p2_e0_reg;
            p3_h_reg    <= h_next;
            p3_base_reg <= p2_base_reg;
        end
    end

    // stage p4: linear index inside the part, c0 + e0 * row
    logic             p4_v_reg, p4_err_reg;
    logic [1:0]       p4_part_reg;
    logic [IDX_W-1:0] p4_lin_reg, lin_next, p4_base_reg;

    assign lin_next = IDX_W'(33'(p3_c0_reg) + 33'(p3_e0_reg) * 33'(p3_h_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_v_reg <= 1'b0;
        end else if (adv) begin
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_err_reg  <= p3_err_reg;
            p4_part_reg <= p3_part_reg;
            p4_lin_reg  <= lin_next;
            p4_base_reg <= p3_base_reg;
        end
    end

    // output register: part offset added, zeroed on a bad index
    logic             out_v_reg, out_err_reg;
    logic [1:0]       out_part_reg;
    logic [IDX_W-1:0] out_idx_reg, idx_next;

    assign idx_next = p4_err_reg ? '0 : p4_base_reg + p4_lin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_err_reg  <= p4_err_reg;
            out_part_reg <= p4_part_reg;
            out_idx_reg  <= idx_next;
        end
    end

    // result beat
    assign m_valid          = out_v_reg;
    assign m_new_index      = out_idx_reg;
    assign m_part           = out_part_reg;
    assign m_index_error    = out_err_reg;
    assign m_split_axis     = axis_reg;
    assign m_left_extent    = left_reg[8:0];
    assign m_right_extent   = 10'(right_reg);
    assign m_separator_size = sep_reg[20:0];

    // a bad index gives a zero index in the left part code
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> m_new_index == '0 && m_part == PART_LEFT)
        else $error("bad index result not cleared");

    // part code is always one of the three parts
    a_part_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_part == PART_LEFT || m_part == PART_RIGHT || m_part == PART_SEP))
        else $error("illegal part code");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result does not change under the stall
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_index) && $stable(m_part))
        else $error("stalled result changed");

endmodule

FILE: dv/tb_grid_bisection_reorder_core.sv
`timescale 1ns / 1ps
// tb_grid_bisection_reorder_core: self-checking bench for the grid bisection reorder core.
// Depends on gbr_pkg and grid_bisection_reorder_core; directed table then random beats.
module tb_grid_bisection_reorder_core;
    import gbr_pkg::*;

    localparam int DIM_LIMIT = 1024;
    localparam int LATENCY   = 36;

    typedef struct packed {
        logic [IDX_W-1:0] new_index;
        logic [1:0]       part;
        logic [1:0]       split_axis;
        logic [8:0]       left_extent;
        logic [9:0]       right_extent;
        logic [20:0]      separator_size;
        logic             index_error;
    } bisect_res_t;

    typedef struct {
        logic [IDX_W-1:0] vertex;
        logic             typed;    // expected result typed in below
        bisect_res_t      res;
    } vertex_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [IDX_W-1:0]     s_vertex_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    wire bisect_res_t     got;

    grid_bisection_reorder_core #(.DIM_MAX(DIM_LIMIT)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_vertex_index(s_vertex_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_index(got.new_index), .m_part(got.part), .m_split_axis(got.split_axis),
        .m_left_extent(got.left_extent), .m_right_extent(got.right_extent),
        .m_separator_size(got.separator_size), .m_index_error(got.index_error)
    );

    always #2 aclk = ~aclk;

    // shadow of the grid dimension registers
    logic [CFG_W-1:0] dim_reg [3];
    bisect_res_t      pending_res [$];
    int               mismatch_cnt = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               hold_cycles = 0;

    function automatic longint unsigned eff_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DIM_LIMIT) return DIM_LIMIT;
        return longint'(v);
    endfunction

    // bisection order of one vertex under the current grid
    function automatic bisect_res_t reorder_vertex(logic [IDX_W-1:0] vtx);
        longint unsigned n [3];
        longint unsigned c [3];
        longint unsigned e [3];
        longint unsigned vol, len, lft, rgt, sep, idx;
        logic [1:0]      axis;
        bisect_res_t     r;
        for (int k = 0; k < 3; k++) n[k] = eff_dim(dim_reg[k]);
        vol = n[0] * n[1] * n[2];
        if (n[0] >= n[1] && n[0] >= n[2]) axis = AXIS_X;
        else if (n[1] >= n[2])            axis = AXIS_Y;
        else                              axis = AXIS_Z;
        len = n[axis];
        lft = (len - 1) / 2;
        rgt = len - 1 - lft;
        sep = vol / len;
        r = '0;
        r.split_axis     = axis;
        r.left_extent    = lft[8:0];
        r.right_extent   = rgt[9:0];
        r.separator_size = sep[20:0];
        if (vtx >= vol) begin
            r.index_error = 1'b1;
            return r;
        end
        c[0] = vtx % n[0];
        c[1] = (vtx / n[0]) % n[1];
        c[2] = vtx / (n[0] * n[1]);
        e = n;
        if (c[axis] < lft) begin
            e[axis] = lft;
            idx = 0;
            r.part = PART_LEFT;
        end else if (c[axis] > lft) begin
            c[axis] -= lft + 1;
            e[axis] = rgt;
            idx = lft * sep;
            r.part = PART_RIGHT;
        end else begin
            c[axis] = 0;
            e[axis] = 1;
            idx = (lft + rgt) * sep;
            r.part = PART_SEP;
        end
        idx += c[0] + c[1] * e[0] + c[2] * e[0] * e[1];
        r.new_index = idx[IDX_W-1:0];
        return r;
    endfunction

    // one register write on the port, with cfg_we low again before the task returns
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx <= REG_GRID_DEPTH) dim_reg[idx] = val;
        @(posedge aclk);
    endtask

    task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] d);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_GRID_DEPTH, d);
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_vertex(logic [IDX_W-1:0] vtx, logic typed, bisect_res_t res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_vertex_index <= vtx;
        pending_res.push_back(typed ? res : reorder_vertex(vtx));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // vertex at random inside the grid, its last vertex, or out of it now and then
    function automatic logic [IDX_W-1:0] pick_vertex();
        longint unsigned vol;
        vol = eff_dim(dim_reg[0]) * eff_dim(dim_reg[1]) * eff_dim(dim_reg[2]);
        case ($urandom_range(9))
            0: return IDX_W'($urandom());
            1: return IDX_W'(vol - 1);
            2: return IDX_W'(vol);
            default: return IDX_W'($urandom_range(32'(vol - 1)));
        endcase
    endfunction

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        bisect_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = pending_res.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("result mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        vertex_row_t table_rows [$];
        bisect_res_t z;
        int          phase;
        dim_reg = '{11'd1, 11'd1, 11'd1};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset grid is one point, which is the separator
        z = '0;
        z.separator_size = 21'd1;
        z.part = PART_SEP;
        table_rows.push_back('{30'd0, 1'b1, z});
        z.part = PART_LEFT;
        z.index_error = 1'b1;
        table_rows.push_back('{30'd1, 1'b1, z});
        table_rows.push_back('{30'h3FFF_FFFF, 1'b1, z});
        foreach (table_rows[k]) send_vertex(table_rows[k].vertex, table_rows[k].typed,
                                            table_rows[k].res);
        drain();

        // zero dims read as 1; unlisted register index ignored
        set_grid(11'd0, 11'd0, 11'd0);
        write_reg(2'd3, 11'h7FF);
        send_vertex(30'd0, 1'b0, z);
        send_vertex(30'd1, 1'b0, z);
        drain();

        // saturating x, then y and z cuts and ties
        set_grid(11'h7FF, 11'd3, 11'd2);
        for (int k = 0; k < 4; k++) send_vertex(pick_vertex(), 1'b0, z);
        send_vertex(30'd511, 1'b0, z);
        send_vertex(30'd512, 1'b0, z);
        drain();
        set_grid(11'd3, 11'd7, 11'd7);
        for (int k = 0; k < 147; k++) send_vertex(IDX_W'(k), 1'b0, z);
        drain();
        set_grid(11'd2, 11'd2, 11'd5);
        for (int k = 0; k < 20; k++) send_vertex(IDX_W'(k), 1'b0, z);
        drain();
        set_grid(11'd1024, 11'd1024, 11'd1024);
        send_vertex(30'h3FFF_FFFF, 1'b0, z);
        send_vertex(30'h2AAA_AAAA, 1'b0, z);
        send_vertex(30'h1555_5555, 1'b0, z);
        drain();

        // random phases over idling modes and grid shapes
        for (phase = 0; phase < 16; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            if (phase % 3 == 0)
                set_grid(CFG_W'($urandom_range(2047)), CFG_W'($urandom_range(2047)),
                         CFG_W'($urandom_range(2047)));
            else
                set_grid(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
                         CFG_W'($urandom_range(1, 12)));
            if (phase == 5) hold_cycles = 200;
            for (int k = 0; k < 40; k++) send_vertex(pick_vertex(), 1'b0, z);
            drain();
        end

        if (mismatch_cnt == 0 && pending_res.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
